/* hw/rtl/iwcd_pkg.sv */
// Shared widths, constants and calendar tables for the ISO week to calendar date block.
package iwcd_pkg;

   localparam int YEAR_W  = 14;
   localparam int WEEK_W  = 6;
   localparam int MONTH_W = 4;
   localparam int DAY_W   = 5;

   // Reciprocal constants: floor(x * MULT >> SHIFT) equals x / divisor for x below 43690.
   localparam int DIV100_MULT  = 5243;
   localparam int DIV100_SHIFT = 19;
   localparam int DIV7_MULT    = 37450;
   localparam int DIV7_SHIFT   = 18;

   localparam int WEEKS_LONG  = 53;
   localparam int WEEKS_SHORT = 52;
   localparam int DAYS_COMMON = 365;

   // Weekday codes, Sunday first.
   localparam logic [2:0] WD_SUNDAY    = 3'd0;
   localparam logic [2:0] WD_MONDAY    = 3'd1;
   localparam logic [2:0] WD_TUESDAY   = 3'd2;
   localparam logic [2:0] WD_WEDNESDAY = 3'd3;
   localparam logic [2:0] WD_THURSDAY  = 3'd4;
   localparam logic [2:0] WD_FRIDAY    = 3'd5;
   localparam logic [2:0] WD_SATURDAY  = 3'd6;

   typedef logic signed [2:0] offset_type;

   // Offset of the Monday of week 1 from January 1, by the weekday of January 1.
   function automatic offset_type week1_offset(input logic [2:0] wd);
      offset_type off;
      case (wd)
         WD_SUNDAY:    off = 3'sd1;
         WD_MONDAY:    off = 3'sd0;
         WD_TUESDAY:   off = -3'sd1;
         WD_WEDNESDAY: off = -3'sd2;
         WD_THURSDAY:  off = -3'sd3;
         WD_FRIDAY:    off = 3'sd3;
         WD_SATURDAY:  off = 3'sd2;
         default:      off = 3'sd0;
      endcase
      return off;
   endfunction

   // Number of days in the year before the first day of the given month.
   function automatic logic [8:0] month_start(input logic [3:0] month, input logic leap);
      logic [8:0] base;
      case (month)
         4'd1:    base = 9'd0;
         4'd2:    base = 9'd31;
         4'd3:    base = 9'd59;
         4'd4:    base = 9'd90;
         4'd5:    base = 9'd120;
         4'd6:    base = 9'd151;
         4'd7:    base = 9'd181;
         4'd8:    base = 9'd212;
         4'd9:    base = 9'd243;
         4'd10:   base = 9'd273;
         4'd11:   base = 9'd304;
         4'd12:   base = 9'd334;
         default: base = 9'd0;
      endcase
      if (month >= 4'd3) begin
         base = base + {8'd0, leap};
      end
      return base;
   endfunction

endpackage

/* hw/rtl/iso_week_to_calendar_date.sv */
// Top level: converts a year and ISO week number to the date of the week's Monday.
// The result strobe travels through a valid shift register beside the data stages,
// so it marks the result of each accepted transaction at the outputs.
// Throughput: one transaction per cycle; eight register stages, busy is tied low.
// The receiver cannot stall, so results leave in order from the last stage.
// Reset (synchronous, active high) clears the stage valid bits; data registers are not reset.
module iso_week_to_calendar_date (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [iwcd_pkg::YEAR_W-1:0]   req_year_in,
   input  logic [iwcd_pkg::WEEK_W-1:0]   req_week_number,
   output logic                          rsp_strobe,
   output logic [iwcd_pkg::YEAR_W-1:0]   rsp_year_out,
   output logic [iwcd_pkg::MONTH_W-1:0]  rsp_month_out,
   output logic [iwcd_pkg::DAY_W-1:0]    rsp_day_of_month
);

   localparam int LATENCY = 8;

   typedef struct packed {
      logic [iwcd_pkg::YEAR_W-1:0] year;
      logic [iwcd_pkg::WEEK_W-1:0] week;
      logic [7:0]                  qu;     // (year + 399) / 100
      logic [7:0]                  qy;     // year / 100
   } s1_type;

   typedef struct packed {
      logic [iwcd_pkg::YEAR_W-1:0] year;
      logic [iwcd_pkg::WEEK_W-1:0] week;
      logic [14:0]                 sum;    // weekday sum before reduction by seven
      logic                        leap_m1;
      logic                        leap_y;
      logic                        leap_p1;
   } s2_type;

   typedef struct packed {
      logic [iwcd_pkg::YEAR_W-1:0] year;
      logic [iwcd_pkg::WEEK_W-1:0] week;
      logic [14:0]                 sum;
      logic [11:0]                 q7;
      logic                        leap_m1;
      logic                        leap_y;
      logic                        leap_p1;
   } s3_type;

   typedef struct packed {
      logic [iwcd_pkg::YEAR_W-1:0] year;
      logic [iwcd_pkg::WEEK_W-1:0] week;
      logic [2:0]                  wd;
      logic                        roll;
      logic                        leap_m1;
      logic                        leap_y;
      logic                        leap_p1;
   } s4_type;

   typedef struct packed {
      logic [iwcd_pkg::YEAR_W-1:0] year;
      logic signed [9:0]           doy;
      logic                        roll;
      logic                        leap_m1;
      logic                        leap_y;
      logic                        leap_p1;
   } s5_type;

   typedef struct packed {
      logic [iwcd_pkg::YEAR_W-1:0] year;
      logic [8:0]                  doy;
      logic                        leap;
   } s6_type;

   typedef struct packed {
      logic [iwcd_pkg::YEAR_W-1:0]  year;
      logic [8:0]                   doy;
      logic                         leap;
      logic [iwcd_pkg::MONTH_W-1:0] month;
   } s7_type;

   typedef struct packed {
      logic [iwcd_pkg::YEAR_W-1:0]  year;
      logic [iwcd_pkg::MONTH_W-1:0] month;
      logic [iwcd_pkg::DAY_W-1:0]   day;
   } s8_type;

   logic               accept;
   logic [LATENCY-1:0] vld_ff, vld_in;
   s1_type             s1_ff, s1_in;
   s2_type             s2_ff, s2_in;
   s3_type             s3_ff, s3_in;
   s4_type             s4_ff, s4_in;
   s5_type             s5_ff, s5_in;
   s6_type             s6_ff, s6_in;
   s7_type             s7_ff, s7_in;
   s8_type             s8_ff, s8_in;

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign vld_in = {vld_ff[LATENCY-2:0], accept};

   // Stage 1: divide year and year + 399 by one hundred.
   always_comb begin
      logic [14:0] u;
      logic [27:0] prod_u;
      logic [27:0] prod_y;
      u            = {1'b0, req_year_in} + 15'd399;
      prod_u       = 28'(u) * 28'(iwcd_pkg::DIV100_MULT);
      prod_y       = 28'(req_year_in) * 28'(iwcd_pkg::DIV100_MULT);
      s1_in.year   = req_year_in;
      s1_in.week   = req_week_number;
      s1_in.qu     = prod_u[iwcd_pkg::DIV100_SHIFT +: 8];
      s1_in.qy     = prod_y[iwcd_pkg::DIV100_SHIFT +: 8];
   end

   // Stage 2: weekday sum for January 1 and the leap flags of the neighboring years.
   always_comb begin
      logic [14:0] u;
      logic [14:0] ry_full;
      logic [6:0]  ry;
      logic [1:0]  m4;
      logic [6:0]  r_alt;
      logic [1:0]  q_alt;
      logic [1:0]  m4_alt;
      u       = {1'b0, s1_ff.year} + 15'd399;
      ry_full = {1'b0, s1_ff.year} - 15'(s1_ff.qy) * 15'd100;
      ry      = ry_full[6:0];
      m4      = s1_ff.year[1:0];

      s2_in.year   = s1_ff.year;
      s2_in.week   = s1_ff.week;
      s2_in.sum    = u + {2'd0, u[14:2]} - {7'd0, s1_ff.qu} + {9'd0, s1_ff.qu[7:2]} + 15'd1;
      s2_in.leap_y = (m4 == 2'd0) && ((ry != 7'd0) || (s1_ff.qy[1:0] == 2'd0));

      r_alt  = (ry == 7'd99) ? 7'd0 : ry + 7'd1;
      q_alt  = s1_ff.qy[1:0] + {1'b0, ry == 7'd99};
      m4_alt = m4 + 2'd1;
      s2_in.leap_p1 = (m4_alt == 2'd0) && ((r_alt != 7'd0) || (q_alt == 2'd0));

      // For year zero the year before is not a multiple of four, so the borrow is harmless.
      r_alt  = (ry == 7'd0) ? 7'd99 : ry - 7'd1;
      q_alt  = s1_ff.qy[1:0] - {1'b0, ry == 7'd0};
      m4_alt = m4 - 2'd1;
      s2_in.leap_m1 = (m4_alt == 2'd0) && ((r_alt != 7'd0) || (q_alt == 2'd0));
   end

   // Stage 3: quotient of the weekday sum by seven.
   always_comb begin
      logic [30:0] prod7;
      prod7         = 31'(s2_ff.sum) * 31'(iwcd_pkg::DIV7_MULT);
      s3_in.year    = s2_ff.year;
      s3_in.week    = s2_ff.week;
      s3_in.sum     = s2_ff.sum;
      s3_in.q7      = prod7[iwcd_pkg::DIV7_SHIFT +: 12];
      s3_in.leap_m1 = s2_ff.leap_m1;
      s3_in.leap_y  = s2_ff.leap_y;
      s3_in.leap_p1 = s2_ff.leap_p1;
   end

   // Stage 4: weekday, week count of the year and rollover into the next year.
   always_comb begin
      logic [14:0] rem_full;
      logic [2:0]  wd;
      logic [5:0]  nweeks;
      logic [3:0]  wd_next;
      rem_full = s3_ff.sum - 15'(s3_ff.q7) * 15'd7;
      wd       = rem_full[2:0];
      nweeks   = ((wd == iwcd_pkg::WD_THURSDAY) ||
                  ((wd == iwcd_pkg::WD_WEDNESDAY) && s3_ff.leap_y)) ?
                 6'(iwcd_pkg::WEEKS_LONG) : 6'(iwcd_pkg::WEEKS_SHORT);
      wd_next  = {1'b0, wd} + 4'd1 + {3'd0, s3_ff.leap_y};
      if (wd_next >= 4'd7) begin
         wd_next = wd_next - 4'd7;
      end

      s4_in.year    = s3_ff.year;
      s4_in.roll    = s3_ff.week > nweeks;
      s4_in.week    = s4_in.roll ? s3_ff.week - nweeks : s3_ff.week;
      s4_in.wd      = s4_in.roll ? wd_next[2:0] : wd;
      s4_in.leap_m1 = s3_ff.leap_m1;
      s4_in.leap_y  = s3_ff.leap_y;
      s4_in.leap_p1 = s3_ff.leap_p1;
   end

   // Stage 5: day of the year of the Monday, which may lie outside the year.
   always_comb begin
      logic [9:0] w7;
      w7            = {1'b0, s4_ff.week, 3'b000} - {4'd0, s4_ff.week};
      s5_in.year    = s4_ff.year;
      s5_in.doy     = $signed(w7) + 10'(iwcd_pkg::week1_offset(s4_ff.wd)) - 10'sd6;
      s5_in.roll    = s4_ff.roll;
      s5_in.leap_m1 = s4_ff.leap_m1;
      s5_in.leap_y  = s4_ff.leap_y;
      s5_in.leap_p1 = s4_ff.leap_p1;
   end

   // Stage 6: move the day into the previous or next year where it falls outside.
   always_comb begin
      logic [14:0] yp;
      logic        leap_p;
      logic        leap_pm1;
      logic [9:0]  days_p;
      logic [9:0]  days_pm1;
      logic [9:0]  doy_u;
      yp       = {1'b0, s5_ff.year} + {14'd0, s5_ff.roll};
      leap_p   = s5_ff.roll ? s5_ff.leap_p1 : s5_ff.leap_y;
      leap_pm1 = s5_ff.roll ? s5_ff.leap_y : s5_ff.leap_m1;
      days_p   = 10'(iwcd_pkg::DAYS_COMMON) + {9'd0, leap_p};
      days_pm1 = 10'(iwcd_pkg::DAYS_COMMON) + {9'd0, leap_pm1};
      doy_u    = s5_ff.doy;
      if (s5_ff.doy <= 10'sd0) begin
         s6_in.year = 14'(yp - 15'd1);
         s6_in.doy  = 9'(doy_u + days_pm1);
         s6_in.leap = leap_pm1;
      end else if (s5_ff.doy > $signed(days_p)) begin
         // Only reachable without rollover, so the following year is year + 1.
         s6_in.year = 14'(yp + 15'd1);
         s6_in.doy  = 9'(doy_u - days_p);
         s6_in.leap = s5_ff.leap_p1;
      end else begin
         s6_in.year = 14'(yp);
         s6_in.doy  = doy_u[8:0];
         s6_in.leap = leap_p;
      end
   end

   // Stage 7: month from eleven parallel compares against the month start table.
   always_comb begin
      logic [3:0] count;
      count = 4'd0;
      for (int k = 2; k <= 12; k++) begin
         if (s6_ff.doy > iwcd_pkg::month_start(4'(k), s6_ff.leap)) begin
            count = count + 4'd1;
         end
      end
      s7_in.year  = s6_ff.year;
      s7_in.doy   = s6_ff.doy;
      s7_in.leap  = s6_ff.leap;
      s7_in.month = count + 4'd1;
   end

   // Stage 8: day within the month.
   always_comb begin
      logic [8:0] day_full;
      day_full    = s7_ff.doy - iwcd_pkg::month_start(s7_ff.month, s7_ff.leap);
      s8_in.year  = s7_ff.year;
      s8_in.month = s7_ff.month;
      s8_in.day   = day_full[iwcd_pkg::DAY_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
      s2_ff <= s2_in;
      s3_ff <= s3_in;
      s4_ff <= s4_in;
      s5_ff <= s5_in;
      s6_ff <= s6_in;
      s7_ff <= s7_in;
      s8_ff <= s8_in;
   end

   assign rsp_strobe       = vld_ff[LATENCY-1];
   assign rsp_year_out     = s8_ff.year;
   assign rsp_month_out    = s8_ff.month;
   assign rsp_day_of_month = s8_ff.day;

`ifndef ASSERT_OFF
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LATENCY rsp_strobe)
      else $error("accepted transaction did not produce a result on time");

   a_origin: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, LATENCY))
      else $error("result strobe without a matching accepted transaction");

   a_month: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_month_out >= 4'd1) && (rsp_month_out <= 4'd12))
      else $error("month out of range");

   a_day: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_day_of_month >= 5'd1) &&
                     ((rsp_month_out != 4'd2) || (rsp_day_of_month <= 5'd29)) &&
                     (!((rsp_month_out == 4'd4) || (rsp_month_out == 4'd6) ||
                        (rsp_month_out == 4'd9) || (rsp_month_out == 4'd11)) ||
                      (rsp_day_of_month <= 5'd30)))
      else $error("day does not fit the month");
`endif

endmodule

/* test/week_date_checker.sv */
// Checker that predicts the Monday of each requested ISO week and compares the block's results.
`timescale 1ns / 100ps

module week_date_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  logic [iwcd_pkg::YEAR_W-1:0]   req_year_in,
   input  logic [iwcd_pkg::WEEK_W-1:0]   req_week_number,
   input  logic                          rsp_strobe,
   input  logic [iwcd_pkg::YEAR_W-1:0]   rsp_year_out,
   input  logic [iwcd_pkg::MONTH_W-1:0]  rsp_month_out,
   input  logic [iwcd_pkg::DAY_W-1:0]    rsp_day_of_month,
   output int                            fail_count,
   output int                            outstanding
);

   typedef struct packed {
      logic [iwcd_pkg::YEAR_W-1:0]  year;
      logic [iwcd_pkg::MONTH_W-1:0] month;
      logic [iwcd_pkg::DAY_W-1:0]   day;
   } calendar_date_type;

   calendar_date_type monday_q[$];

   // Years are offset by one 400-year cycle so that year -1 stays positive.
   function automatic bit year_is_leap(input int y);
      int u;
      u = y + 400;
      return ((u % 4 == 0) && (u % 100 != 0)) || (u % 400 == 0);
   endfunction

   function automatic int days_in_year(input int y);
      return year_is_leap(y) ? 366 : 365;
   endfunction

   function automatic logic [2:0] new_year_weekday(input int y);
      int u;
      u = y + 399;
      return 3'((u + u / 4 - u / 100 + u / 400 + 1) % 7);
   endfunction

   // Distance from January 1 to the Monday that opens week 1.
   function automatic int week1_shift(input logic [2:0] wd);
      case (wd)
         iwcd_pkg::WD_SUNDAY:    return 1;
         iwcd_pkg::WD_MONDAY:    return 0;
         iwcd_pkg::WD_TUESDAY:   return -1;
         iwcd_pkg::WD_WEDNESDAY: return -2;
         iwcd_pkg::WD_THURSDAY:  return -3;
         iwcd_pkg::WD_FRIDAY:    return 3;
         iwcd_pkg::WD_SATURDAY:  return 2;
         default:                return 0;
      endcase
   endfunction

   function automatic int weeks_in_year(input int y);
      logic [2:0] wd;
      wd = new_year_weekday(y);
      return (wd == iwcd_pkg::WD_THURSDAY ||
              (wd == iwcd_pkg::WD_WEDNESDAY && year_is_leap(y))) ? 53 : 52;
   endfunction

   function automatic int days_in_month(input int y, input int m);
      case (m) inside
         2:             return year_is_leap(y) ? 29 : 28;
         4, 6, 9, 11:   return 30;
         default:       return 31;
      endcase
   endfunction

   function automatic calendar_date_type week_monday(
                                          input logic [iwcd_pkg::YEAR_W-1:0] year_in,
                                          input logic [iwcd_pkg::WEEK_W-1:0] week_in);
      int y;
      int w;
      int nweeks;
      int doy;
      int m;
      calendar_date_type d;
      y = int'(year_in);
      w = int'(week_in);
      nweeks = weeks_in_year(y);
      if (w > nweeks) begin
         w = w - nweeks;
         y = y + 1;
      end
      doy = (w - 1) * 7 + 1 + week1_shift(new_year_weekday(y));
      if (doy <= 0) begin
         y = y - 1;
         doy = doy + days_in_year(y);
      end else if (doy > days_in_year(y)) begin
         doy = doy - days_in_year(y);
         y = y + 1;
      end
      m = 1;
      while (m < 12 && doy > days_in_month(y, m)) begin
         doy = doy - days_in_month(y, m);
         m = m + 1;
      end
      // Years outside the port range wrap modulo the port width.
      d.year = y[iwcd_pkg::YEAR_W-1:0];
      d.month = m[iwcd_pkg::MONTH_W-1:0];
      d.day = doy[iwcd_pkg::DAY_W-1:0];
      return d;
   endfunction

   always @(posedge clock) begin
      calendar_date_type want;
      if (reset) begin
         monday_q.delete();
         outstanding <= 0;
         fail_count <= 0;
      end else begin
         // Results are retired before the new transaction is queued.
         if (rsp_strobe) begin
            if (monday_q.size() == 0) begin
               $error("unexpected result: year_out %0d, month_out %0d, day_of_month %0d",
                      rsp_year_out, rsp_month_out, rsp_day_of_month);
               fail_count <= fail_count + 1;
            end else begin
               want = monday_q.pop_front();
               if (rsp_year_out !== want.year || rsp_month_out !== want.month ||
                   rsp_day_of_month !== want.day) begin
                  fail_count <= fail_count + 1;
               end
               if (rsp_year_out !== want.year) begin
                  $error("year_out: expected %0d, actual %0d", want.year, rsp_year_out);
               end
               if (rsp_month_out !== want.month) begin
                  $error("month_out: expected %0d, actual %0d", want.month, rsp_month_out);
               end
               if (rsp_day_of_month !== want.day) begin
                  $error("day_of_month: expected %0d, actual %0d", want.day, rsp_day_of_month);
               end
            end
         end
         if (start && !busy) begin
            monday_q.push_back(week_monday(req_year_in, req_week_number));
         end
         outstanding <= monday_q.size();
      end
   end

endmodule

/* test/tb.sv */
// Testbench top: drives year and week transactions into the block and reports the verdict.
`timescale 1ns / 100ps

module tb;

   localparam int RANDOM_ITEMS = 630;
   localparam int STALL_LIMIT  = 400;
   localparam int DRAIN_CYCLES = 20;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          start = 1'b0;
   logic                          busy;
   logic [iwcd_pkg::YEAR_W-1:0]   req_year_in = '0;
   logic [iwcd_pkg::WEEK_W-1:0]   req_week_number = '0;
   logic                          rsp_strobe;
   logic [iwcd_pkg::YEAR_W-1:0]   rsp_year_out;
   logic [iwcd_pkg::MONTH_W-1:0]  rsp_month_out;
   logic [iwcd_pkg::DAY_W-1:0]    rsp_day_of_month;
   int                            fail_count;
   int                            outstanding;
   int                            stall_cycles = 0;

   always #5 clock = ~clock;

   iso_week_to_calendar_date u_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_year_in      (req_year_in),
      .req_week_number  (req_week_number),
      .rsp_strobe       (rsp_strobe),
      .rsp_year_out     (rsp_year_out),
      .rsp_month_out    (rsp_month_out),
      .rsp_day_of_month (rsp_day_of_month)
   );

   week_date_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_year_in      (req_year_in),
      .req_week_number  (req_week_number),
      .rsp_strobe       (rsp_strobe),
      .rsp_year_out     (rsp_year_out),
      .rsp_month_out    (rsp_month_out),
      .rsp_day_of_month (rsp_day_of_month),
      .fail_count       (fail_count),
      .outstanding      (outstanding)
   );

   // Watchdog: any cycle without an accepted transaction or result counts toward the limit.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("tb: FAIL");
            $finish;
         end
      end
   end

   // Holds the transaction until it is accepted, then idles for the gap given, if any.
   task automatic send_week(input logic [iwcd_pkg::YEAR_W-1:0] year,
                            input logic [iwcd_pkg::WEEK_W-1:0] week,
                            input int gap);
      req_year_in <= year;
      req_week_number <= week;
      start <= 1'b1;
      @(posedge clock);
      while (busy) begin
         @(posedge clock);
      end
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   initial begin
      int burst_left;
      bit no_idle;
      int kind;
      logic [iwcd_pkg::YEAR_W-1:0] y;
      logic [iwcd_pkg::WEEK_W-1:0] w;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Week zero of year zero lands in year -1, which wraps to the top of the year range.
      send_week(14'd0, 6'd0, $urandom_range(0, 4));
      send_week(14'd16383, 6'd63, $urandom_range(0, 4));
      send_week(14'd16383, 6'd0, $urandom_range(0, 4));
      send_week(14'd0, 6'd63, $urandom_range(0, 4));
      send_week(14'd0, 6'd1, $urandom_range(0, 4));
      send_week(14'd1, 6'd1, $urandom_range(0, 4));
      send_week(14'd9999, 6'd52, $urandom_range(0, 4));
      send_week(14'd9999, 6'd53, $urandom_range(0, 4));
      // A year that opens on a Sunday starts week 1 the next day.
      send_week(14'd2017, 6'd1, $urandom_range(0, 4));
      send_week(14'd2018, 6'd1, $urandom_range(0, 4));
      send_week(14'd2019, 6'd1, $urandom_range(0, 4));
      send_week(14'd2021, 6'd1, $urandom_range(0, 4));
      send_week(14'd2022, 6'd1, $urandom_range(0, 4));
      // Thursday start and leap Wednesday start both give a 53-week year.
      send_week(14'd2015, 6'd1, $urandom_range(0, 4));
      send_week(14'd2015, 6'd53, $urandom_range(0, 4));
      send_week(14'd2020, 6'd53, $urandom_range(0, 4));
      send_week(14'd2025, 6'd53, $urandom_range(0, 4));
      send_week(14'd2021, 6'd53, $urandom_range(0, 4));
      send_week(14'd2018, 6'd0, $urandom_range(0, 4));
      send_week(14'd2020, 6'd63, $urandom_range(0, 4));
      send_week(14'd2000, 6'd9, $urandom_range(0, 4));
      send_week(14'd1900, 6'd9, $urandom_range(0, 4));
      send_week(14'd2100, 6'd10, $urandom_range(0, 4));
      send_week(14'd8191, 6'd32, $urandom_range(0, 4));

      burst_left = 0;
      no_idle = 1'b0;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(8, 40);
            no_idle = ($urandom_range(0, 3) == 0);
         end
         burst_left = burst_left - 1;
         kind = $urandom_range(0, 9);
         if (kind < 7) begin
            y = 14'($urandom_range(1, 9999));
            w = 6'($urandom_range(1, 53));
         end else if (kind == 7) begin
            y = 14'($urandom_range(1, 9999));
            w = ($urandom_range(0, 1) == 0) ? 6'd0 : 6'($urandom_range(54, 63));
         end else begin
            y = 14'($urandom);
            w = 6'($urandom);
         end
         send_week(y, w, no_idle ? 0 : $urandom_range(0, 4));
      end
      start <= 1'b0;

      @(posedge clock);
      while (outstanding != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule

/* files.f */
hw/rtl/iwcd_pkg.sv
hw/rtl/iso_week_to_calendar_date.sv
test/week_date_checker.sv
test/tb.sv
